>>> hdl/bswt_pkg.sv
// ----------------------------------------------------------------------------
// bswt_pkg
// Shared types and codes of the byte-stream word tokenizer.
// ----------------------------------------------------------------------------
package bswt_pkg;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_END_TOKEN = 2'd1,
    KIND_END_TEXT  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_TOKEN_MODE = 2'd0,
    REG_FOLD_CASE  = 2'd1,
    REG_KEEP_PUNCT = 2'd2
  } reg_idx_t;

  // Result slots of one item, in emission order
  localparam int unsigned SLOT_PRE_END = 0;
  localparam int unsigned SLOT_CHAR    = 1;
  localparam int unsigned SLOT_POST_END = 2;
  localparam int unsigned SLOT_EOT_END = 3;
  localparam int unsigned SLOT_EOT     = 4;
  localparam int unsigned NUM_SLOTS    = 5;

  typedef struct packed {
    logic [7:0]           ch;
    logic [NUM_SLOTS-1:0] mask;
  } plan_t;

endpackage

>>> hdl/bswt_front.sv
// ----------------------------------------------------------------------------
// bswt_front
// Classifies each text byte and turns it into a plan of up to four results.
// ----------------------------------------------------------------------------
module bswt_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 in_tuser,
  input  logic                 in_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic                 cfg_data,
  input  logic                 q_full,
  output logic                 push,
  output bswt_pkg::plan_t      plan
);

  logic mode_r, mode_nxt;
  logic fold_r, fold_nxt;
  logic keep_r, keep_nxt;
  logic in_token_r, in_token_nxt;
  logic is_space, is_alnum, is_punct, is_upper;
  logic tok;
  logic accept;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    is_space = in_tdata inside {[8'd9:8'd13], 8'd32};
    is_alnum = in_tdata inside {[8'd48:8'd57], [8'd65:8'd90], [8'd97:8'd122]};
    is_upper = in_tdata inside {[8'd65:8'd90]};
    is_punct = (in_tdata inside {[8'd33:8'd126]}) && !is_alnum;
  end

  always_comb begin
    tok       = in_token_r;
    plan.mask = '0;
    plan.ch   = in_tdata;
    if (in_tuser) begin
      if (!mode_r) begin
        if (is_space) begin
          plan.mask[bswt_pkg::SLOT_PRE_END] = tok;
          tok = 1'b0;
        end else begin
          plan.mask[bswt_pkg::SLOT_CHAR] = 1'b1;
          tok = 1'b1;
        end
      end else if (is_alnum) begin
        plan.mask[bswt_pkg::SLOT_CHAR] = 1'b1;
        if (fold_r && is_upper) begin
          plan.ch = in_tdata | 8'h20;
        end
        tok = 1'b1;
      end else if (is_punct) begin
        plan.mask[bswt_pkg::SLOT_PRE_END] = tok;
        tok = 1'b0;
        if (keep_r) begin
          plan.mask[bswt_pkg::SLOT_CHAR]     = 1'b1;
          plan.mask[bswt_pkg::SLOT_POST_END] = 1'b1;
        end
      end else if (is_space) begin
        plan.mask[bswt_pkg::SLOT_PRE_END] = tok;
        tok = 1'b0;
      end
    end
    if (in_tlast) begin
      plan.mask[bswt_pkg::SLOT_EOT_END] = tok;
      plan.mask[bswt_pkg::SLOT_EOT]     = 1'b1;
      tok = 1'b0;
    end
  end

  assign push         = accept && (|plan.mask);
  assign in_token_nxt = accept ? tok : in_token_r;

  always_comb begin
    mode_nxt = mode_r;
    fold_nxt = fold_r;
    keep_nxt = keep_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bswt_pkg::REG_TOKEN_MODE: mode_nxt = cfg_data;
        bswt_pkg::REG_FOLD_CASE:  fold_nxt = cfg_data;
        bswt_pkg::REG_KEEP_PUNCT: keep_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b1;
      fold_r     <= 1'b1;
      keep_r     <= 1'b1;
      in_token_r <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      fold_r     <= fold_nxt;
      keep_r     <= keep_nxt;
      in_token_r <= in_token_nxt;
    end
  end

endmodule

>>> hdl/bswt_fifo.sv
// ----------------------------------------------------------------------------
// bswt_fifo
// Short plan queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
module bswt_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bswt_pkg::plan_t wr_plan,
  output logic            full,
  input  logic            pop,
  output logic            rd_valid,
  output bswt_pkg::plan_t rd_plan
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bswt_pkg::plan_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_plan  = mem[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_plan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hdl/bswt_back.sv
// ----------------------------------------------------------------------------
// bswt_back
// Expands queued plans into single results and holds them in the output register.
// ----------------------------------------------------------------------------
module bswt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_valid,
  input  bswt_pkg::plan_t rd_plan,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,
  output logic [1:0]      out_tuser,
  output logic            out_tlast
);

  bswt_pkg::plan_t cur_r, cur_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [7:0]                     out_char_r;
  bswt_pkg::kind_t                out_kind_r;
  logic                           out_last_r;
  logic [bswt_pkg::NUM_SLOTS-1:0] sel, rest;
  logic                           out_free, cur_busy, emit, cur_done;
  bswt_pkg::kind_t                sel_kind;

  assign sel      = cur_r.mask & (~cur_r.mask + 1'b1);
  assign rest     = cur_r.mask & ~sel;
  assign out_free = !out_valid_r || out_tready;
  assign cur_busy = |cur_r.mask;
  assign emit     = out_free && cur_busy;
  assign cur_done = !cur_busy || (emit && (rest == '0));
  assign pop      = cur_done && rd_valid;

  always_comb begin
    if (sel[bswt_pkg::SLOT_CHAR]) begin
      sel_kind = bswt_pkg::KIND_CHAR;
    end else if (sel[bswt_pkg::SLOT_EOT]) begin
      sel_kind = bswt_pkg::KIND_END_TEXT;
    end else begin
      sel_kind = bswt_pkg::KIND_END_TOKEN;
    end
  end

  always_comb begin
    cur_nxt = cur_r;
    if (pop) begin
      cur_nxt = rd_plan;
    end else if (emit) begin
      cur_nxt.mask = rest;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= sel[bswt_pkg::SLOT_CHAR] ? cur_r.ch : 8'd0;
      out_kind_r <= sel_kind;
      out_last_r <= (rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.mask  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r.mask  <= cur_nxt.mask;
      out_valid_r <= out_valid_nxt;
    end
    cur_r.ch <= cur_nxt.ch;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_plan_size: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cur_r.mask) <= 4)
    else $error("plan holds more than four results");

  a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == bswt_pkg::KIND_END_TEXT) |-> out_last_r)
    else $error("end-of-text marker not last of its item");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r != bswt_pkg::KIND_CHAR) |-> (out_char_r == 8'd0))
    else $error("marker carries a character");
`endif

endmodule

>>> hdl/byte_stream_word_tokenizer_core.sv
// ----------------------------------------------------------------------------
// byte_stream_word_tokenizer_core
// Byte-stream tokenizer emitting token characters and token/text end markers.
// ----------------------------------------------------------------------------
// Input stream: one text byte per transfer in in_tdata, in_tuser says the
// byte is present, in_tlast marks the final item of the text. A new item is
// taken every cycle while the plan queue has room.
// Output stream: one result per transfer; out_tuser is the kind (token
// character, end of token, end of text), out_tdata the character (zero for
// markers), out_tlast the last result caused by one input item.
// Each item yields zero to four results; the back end emits one result per
// cycle unless stalled, so sustained input rate is one item per cycle while
// items produce at most one result each. Results pass the plan queue, the
// current-plan register and the output register. The plan queue (QUEUE_DEPTH
// entries) and the output register absorb bursts; when the receiver stalls,
// the output holds and the queue fills, after which in_tready drops.
// Configuration: cfg_index 0 token mode, 1 case folding, 2 punctuation
// tokens; bit 0 of cfg_data is written. Reset sets all three to 1, closes
// any open token and empties the queue.
// ----------------------------------------------------------------------------
module byte_stream_word_tokenizer_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tuser,   // [0] byte_valid
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [1:0] out_tuser,  // [1:0] kind
  output logic       out_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data
);

  bswt_pkg::plan_t wr_plan, rd_plan;
  logic            push, pop, q_full, rd_valid;

  bswt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .plan      (wr_plan)
  );

  bswt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_plan  (wr_plan),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (rd_valid),
    .rd_plan  (rd_plan)
  );

  bswt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_valid   (rd_valid),
    .rd_plan    (rd_plan),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
